[sv/lccp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_pkg: shared definitions for the linked character cell pool
// Widths, codes and the controller state type used by the interfaces and
// the pool itself.
// ----------------------------------------------------------------------------
package lccp_pkg;

  // Pool geometry. The pointer field is fixed at ten bits.
  localparam int POOL_CELLS = 1024;
  localparam int MAX_READ   = 64;
  localparam int IDX_W      = 10;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = $clog2(POOL_CELLS);
  localparam int LINK_W     = $clog2(POOL_CELLS + 1);
  localparam int STEP_W     = $clog2(POOL_CELLS + 1);
  localparam int CNT_W      = $clog2(MAX_READ);
  localparam int WORD_W     = LINK_W + CHAR_W;

  // Request modes.
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPTR = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_READ,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

[sv/lccp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_in_if / lccp_out_if: request and result channels
// Valid/ready channels carrying one request or one result of the pool.
// ----------------------------------------------------------------------------
interface lccp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [lccp_pkg::CHAR_W-1:0] char_value;
  logic [lccp_pkg::IDX_W-1:0]  pointer;

  modport source (output valid, output mode, output char_value, output pointer,
                  input ready);
  modport sink   (input valid, input mode, input char_value, input pointer,
                  output ready);
endinterface

interface lccp_out_if;
  logic                        valid;
  logic                        ready;
  logic [lccp_pkg::IDX_W-1:0]  cell_index;
  logic [lccp_pkg::CHAR_W-1:0] char_out;
  logic                        last;
  logic [1:0]                  status;

  modport source (output valid, output cell_index, output char_out, output last,
                  output status, input ready);
  modport sink   (input valid, input cell_index, input char_out, input last,
                  input status, output ready);
endinterface
`default_nettype wire

[sv/linked_char_cell_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linked_char_cell_pool: free-list pool of linked character cells
// Allocates, frees and reads byte strings held as linked cells in one
// synchronous memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell memory, giving every cell a
// zero byte and a link to the next cell; no request is taken during that
// pass. Afterwards one request is handled at a time. An alloc first reads
// the cell at the free head, then writes the byte back and moves the head.
// A free walks the chain one cell per cycle, clearing each byte, over at
// most as many cells as the pool holds (all of them on a cyclic chain). A
// read emits one result per cycle while the result side keeps up, at most
// 64 results. Rejected requests (pool full, bad pointer) are answered from
// a single response state. The walk rate is set by the single memory read
// port, whose registered output lies in the loop from one cell's link to
// the next cell's address. Results sit in an output register, so a new
// request can be accepted while the last result of the previous one still
// waits to be taken.
// ----------------------------------------------------------------------------
module linked_char_cell_pool (
  input  wire           clk,
  input  wire           rst_n,
  lccp_in_if.sink       in_ch,
  lccp_out_if.source    out_ch
);

  localparam int ADDR_W = lccp_pkg::ADDR_W;
  localparam int LINK_W = lccp_pkg::LINK_W;
  localparam int CHAR_W = lccp_pkg::CHAR_W;
  localparam int IDX_W  = lccp_pkg::IDX_W;
  localparam int STEP_W = lccp_pkg::STEP_W;
  localparam int CNT_W  = lccp_pkg::CNT_W;
  localparam int WORD_W = lccp_pkg::WORD_W;

  // Each memory word holds a cell's link above its byte.
  logic [WORD_W-1:0] cell_mem [lccp_pkg::POOL_CELLS];

  lccp_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0] init_r, init_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  // Memory port controls.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] mem_q_r;
  logic              fwd_r;
  logic [WORD_W-1:0] fwd_data_r;

  // Decoded conditions.
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [WORD_W-1:0] word_q;
  logic [CHAR_W-1:0] q_byte;
  logic [LINK_W-1:0] q_link;
  logic              head_full;
  logic              ptr_bad;
  logic              link_end;
  logic [STEP_W-1:0] steps_inc;
  logic              free_stop;
  logic              read_stop;

  // A read that meets a write to the same cell in one cycle sees the new word.
  assign word_q = fwd_r ? fwd_data_r : mem_q_r;
  assign q_byte = word_q[CHAR_W-1:0];
  assign q_link = word_q[WORD_W-1:CHAR_W];

  assign in_ch.ready = (state_r == lccp_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign head_full = (head_r >= LINK_W'(lccp_pkg::POOL_CELLS));
  assign ptr_bad   = ({1'b0, in_ch.pointer} >= (IDX_W + 1)'(lccp_pkg::POOL_CELLS));
  assign link_end  = (q_link >= LINK_W'(lccp_pkg::POOL_CELLS));
  assign steps_inc = steps_r + STEP_W'(1);
  assign free_stop = (q_byte == '0) || link_end ||
                     (steps_inc >= STEP_W'(lccp_pkg::POOL_CELLS));
  assign read_stop = (q_byte == '0) || link_end ||
                     (n_r == CNT_W'(lccp_pkg::MAX_READ - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lccp_pkg::S_INIT: begin
        if (init_r == ADDR_W'(lccp_pkg::POOL_CELLS - 1)) state_nxt = lccp_pkg::S_IDLE;
      end
      lccp_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            lccp_pkg::MODE_ALLOC: state_nxt = head_full ? lccp_pkg::S_RESP
                                                        : lccp_pkg::S_ALLOC;
            lccp_pkg::MODE_FREE:  state_nxt = ptr_bad ? lccp_pkg::S_RESP
                                                      : lccp_pkg::S_FREE;
            lccp_pkg::MODE_READ:  state_nxt = ptr_bad ? lccp_pkg::S_RESP
                                                      : lccp_pkg::S_READ;
            default:              state_nxt = lccp_pkg::S_IDLE;
          endcase
        end
      end
      lccp_pkg::S_ALLOC: begin
        if (out_free) state_nxt = lccp_pkg::S_IDLE;
      end
      lccp_pkg::S_FREE: begin
        if (free_stop && out_free) state_nxt = lccp_pkg::S_IDLE;
      end
      lccp_pkg::S_READ: begin
        if (read_stop && out_free) state_nxt = lccp_pkg::S_IDLE;
      end
      lccp_pkg::S_RESP: begin
        if (out_free) state_nxt = lccp_pkg::S_IDLE;
      end
      default: state_nxt = lccp_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    init_nxt       = init_r;
    head_nxt       = head_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    n_nxt          = n_r;
    mode_nxt       = mode_r;
    char_nxt       = char_r;
    ptr_nxt        = ptr_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = '0;
    out_load       = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    case (state_r)
      lccp_pkg::S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = init_r;
        wr_data  = {LINK_W'(init_r) + LINK_W'(1), CHAR_W'(0)};
        init_nxt = init_r + ADDR_W'(1);
      end
      lccp_pkg::S_IDLE: begin
        if (in_acc) begin
          mode_nxt  = in_ch.mode;
          char_nxt  = in_ch.char_value;
          ptr_nxt   = in_ch.pointer;
          steps_nxt = '0;
          n_nxt     = '0;
          if (in_ch.mode == lccp_pkg::MODE_ALLOC) begin
            if (!head_full) begin
              rd_en   = 1'b1;
              rd_addr = head_r[ADDR_W-1:0];
              cur_nxt = head_r[ADDR_W-1:0];
            end
          end else if (!ptr_bad) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(in_ch.pointer);
            cur_nxt = ADDR_W'(in_ch.pointer);
          end
        end
      end
      lccp_pkg::S_ALLOC: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_data        = {q_link, char_r};
          head_nxt       = q_link;
          out_load       = 1'b1;
          out_idx_nxt    = IDX_W'(cur_r);
          out_char_nxt   = char_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = lccp_pkg::ST_OK;
        end
      end
      lccp_pkg::S_FREE: begin
        if (free_stop) begin
          // The terminating cell takes the old head; the chain becomes the head.
          if (out_free) begin
            wr_en          = 1'b1;
            wr_data        = {head_r, CHAR_W'(0)};
            head_nxt       = LINK_W'(ptr_r);
            out_load       = 1'b1;
            out_idx_nxt    = ptr_r;
            out_char_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = lccp_pkg::ST_OK;
          end
        end else begin
          wr_en     = 1'b1;
          wr_data   = {q_link, CHAR_W'(0)};
          rd_en     = 1'b1;
          rd_addr   = q_link[ADDR_W-1:0];
          cur_nxt   = q_link[ADDR_W-1:0];
          steps_nxt = steps_inc;
        end
      end
      lccp_pkg::S_READ: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_idx_nxt  = IDX_W'(cur_r);
          out_char_nxt = q_byte;
          out_last_nxt = read_stop;
          if (q_byte == '0) begin
            out_status_nxt = lccp_pkg::ST_OK;
          end else if (n_r == CNT_W'(lccp_pkg::MAX_READ - 1)) begin
            out_status_nxt = lccp_pkg::ST_TRUNC;
          end else if (link_end) begin
            out_status_nxt = lccp_pkg::ST_BADPTR;
          end else begin
            out_status_nxt = lccp_pkg::ST_OK;
            rd_en          = 1'b1;
            rd_addr        = q_link[ADDR_W-1:0];
            cur_nxt        = q_link[ADDR_W-1:0];
            n_nxt          = n_r + CNT_W'(1);
          end
        end
      end
      lccp_pkg::S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_nxt = '0;
          out_last_nxt = 1'b1;
          if (mode_r == lccp_pkg::MODE_ALLOC) begin
            out_idx_nxt    = '0;
            out_status_nxt = lccp_pkg::ST_FULL;
          end else begin
            out_idx_nxt    = ptr_r;
            out_status_nxt = lccp_pkg::ST_BADPTR;
          end
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Cell memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= cell_mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lccp_pkg::S_INIT;
      init_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (rd_en) fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    n_r          <= n_nxt;
    mode_r       <= mode_nxt;
    char_r       <= char_nxt;
    ptr_r        <= ptr_nxt;
    out_idx_r    <= out_idx_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_index = out_idx_r;
  assign out_ch.char_out   = out_char_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.status     = out_status_r;

  // The free head always names a cell or the end of the free list.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LINK_W'(lccp_pkg::POOL_CELLS))
    else $error("free head beyond end of pool");

  // Only the final result of a request may carry a non-zero status.
  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_status_r == lccp_pkg::ST_OK)
    else $error("status on a non-final result");

  // A held result is never overwritten by the controller.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_idx_r) &&
      $stable(out_char_r) && $stable(out_last_r) && $stable(out_status_r))
    else $error("pending result overwritten");

  // A free walk never passes more cells than the pool holds.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lccp_pkg::S_FREE |-> steps_r < STEP_W'(lccp_pkg::POOL_CELLS))
    else $error("free walk overran the pool");

  // No request is taken while the sweep after reset is running.
  a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lccp_pkg::S_INIT |-> !in_ch.ready && !out_valid_r)
    else $error("activity during reset sweep");

endmodule
`default_nettype wire

[dv/tb_linked_char_cell_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_linked_char_cell_pool: self-checking bench for the character cell pool
// Drives alloc, free and read requests, keeps its own copy of the cell bytes,
// links and free head, and checks every result in order against it.
// ----------------------------------------------------------------------------
module tb_linked_char_cell_pool;

  localparam int IDX_W      = lccp_pkg::IDX_W;
  localparam int CHAR_W     = lccp_pkg::CHAR_W;
  localparam int LINK_W     = lccp_pkg::LINK_W;
  localparam int POOL_CELLS = lccp_pkg::POOL_CELLS;
  localparam int MAX_READ   = lccp_pkg::MAX_READ;

  // The pool decodes only three modes. The fourth is sent as noise and must
  // produce nothing at all.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Longest stretch without any handshake that a correct pool can show: the
  // clearing sweep after reset, a free walking the whole pool, and long gaps
  // from either side all stay well below this.
  localparam int WATCHDOG_LIMIT = 6000;

  // Cycles allowed after the last expected result, to catch stray results.
  localparam int DRAIN_CYCLES = 80;

  // Only the first mismatches are printed, so a broken pool cannot flood the log.
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic [1:0]        status;
  } pool_result_t;

  // One row of the directed table. Where typed is set, the row carries the
  // single result it must give; otherwise the shadow pool decides.
  typedef struct {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] char_value;
    logic [IDX_W-1:0]  pointer;
    bit                typed;
    pool_result_t      want;
  } stim_row_t;

  localparam pool_result_t FROM_SHADOW = '0;
  localparam int N_ROWS = 21;

  // The directed walk starts from the state after reset: every byte zero and
  // the free list running 0, 1, 2 ... in order. The rows build two short
  // strings, read them, free them and leave the free list in order again, so
  // that the long string after it lands in consecutive cells.
  stim_row_t directed_rows [N_ROWS] = '{
    // An untouched cell reads as a bare terminator, at both ends of the pool.
    '{lccp_pkg::MODE_READ,  8'h00, 10'd0,    1'b1, '{10'd0,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_READ,  8'hFF, 10'd1023, 1'b1, '{10'd1023, 8'h00, 1'b1, lccp_pkg::ST_OK}},
    // The unused mode must leave the pool alone and answer nothing.
    '{MODE_UNUSED,          8'hFF, 10'd1023, 1'b0, FROM_SHADOW},
    // A three character string in cells 0 to 3, taken in free list order.
    '{lccp_pkg::MODE_ALLOC, 8'h68, 10'd0,    1'b1, '{10'd0,    8'h68, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'hFF, 10'd512,  1'b1, '{10'd1,    8'hFF, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'h01, 10'd0,    1'b1, '{10'd2,    8'h01, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'h00, 10'd0,    1'b1, '{10'd3,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_READ,  8'h00, 10'd0,    1'b0, FROM_SHADOW},
    '{lccp_pkg::MODE_READ,  8'h00, 10'd2,    1'b0, FROM_SHADOW},
    // Freeing the string gives one plain acknowledgement at the pointer.
    '{lccp_pkg::MODE_FREE,  8'hFF, 10'd0,    1'b1, '{10'd0,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_READ,  8'h00, 10'd0,    1'b0, FROM_SHADOW},
    '{lccp_pkg::MODE_ALLOC, 8'h80, 10'd0,    1'b1, '{10'd0,    8'h80, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'h7F, 10'd0,    1'b1, '{10'd1,    8'h7F, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'h00, 10'd0,    1'b1, '{10'd2,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_READ,  8'h00, 10'd1,    1'b0, FROM_SHADOW},
    // Freeing from the middle of a string: cell 0 keeps its byte.
    '{lccp_pkg::MODE_FREE,  8'h00, 10'd1,    1'b1, '{10'd1,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_READ,  8'h00, 10'd0,    1'b0, FROM_SHADOW},
    '{lccp_pkg::MODE_ALLOC, 8'h55, 10'h3FF,  1'b1, '{10'd1,    8'h55, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'hAA, 10'h2AA,  1'b1, '{10'd2,    8'hAA, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_ALLOC, 8'h00, 10'h155,  1'b1, '{10'd3,    8'h00, 1'b1, lccp_pkg::ST_OK}},
    '{lccp_pkg::MODE_FREE,  8'h00, 10'd0,    1'b1, '{10'd0,    8'h00, 1'b1, lccp_pkg::ST_OK}}
  };

  logic clk;
  logic rst_n;
  logic result_ready = 1'b0;

  lccp_in_if  req_if ();
  lccp_out_if res_if ();

  assign res_if.ready = result_ready;

  linked_char_cell_pool dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the pool. Links are one bit wider than an index so that
  // the end-of-list marker (the pool size) fits.
  logic [CHAR_W-1:0] cell_text [POOL_CELLS];
  logic [LINK_W-1:0] cell_next [POOL_CELLS];
  logic [LINK_W-1:0] next_free;

  pool_result_t fresh_results [$];    // results of the request just accepted
  pool_result_t awaited_results [$];  // results still owed by the pool
  int           live_strings [$];     // first cells of strings believed intact

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_seen = 0;
  int truncated_seen = 0;
  int broken_seen = 0;

  function automatic void add_result(input int idx, input logic [CHAR_W-1:0] ch,
                                     input logic lst, input logic [1:0] st);
    pool_result_t r;
    r.cell_index = idx[IDX_W-1:0];
    r.char_out   = ch;
    r.last       = lst;
    r.status     = st;
    fresh_results.push_back(r);
  endfunction

  // Applies one accepted request to the shadow pool and leaves the results
  // it should cause in fresh_results.
  function automatic void apply_request(input logic [1:0] mode,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [IDX_W-1:0] ptr);
    int  cur;
    int  steps;
    int  n;
    int  head;
    bit  stop;
    fresh_results.delete();
    cur  = int'(ptr);
    stop = 1'b0;
    case (mode)
      lccp_pkg::MODE_ALLOC: begin
        head = int'(next_free);
        if (head >= POOL_CELLS) begin
          add_result(0, 8'h00, 1'b1, lccp_pkg::ST_FULL);
        end else begin
          cell_text[head] = ch;
          next_free = cell_next[head];
          add_result(head, ch, 1'b1, lccp_pkg::ST_OK);
        end
      end
      lccp_pkg::MODE_FREE: begin
        if (cur >= POOL_CELLS) begin
          add_result(cur, 8'h00, 1'b1, lccp_pkg::ST_BADPTR);
        end else begin
          // Clear bytes up to the terminator. A cleared cell with no onward
          // link, or a walk as long as the pool (a loop), also ends it.
          steps = 0;
          while (!stop) begin
            steps++;
            if (cell_text[cur] == 8'h00) begin
              stop = 1'b1;
            end else begin
              cell_text[cur] = 8'h00;
              if (cell_next[cur] >= POOL_CELLS || steps >= POOL_CELLS) stop = 1'b1;
              else cur = int'(cell_next[cur]);
            end
          end
          cell_next[cur] = next_free;
          next_free = LINK_W'(ptr);
          add_result(int'(ptr), 8'h00, 1'b1, lccp_pkg::ST_OK);
        end
      end
      lccp_pkg::MODE_READ: begin
        if (cur >= POOL_CELLS) begin
          add_result(cur, 8'h00, 1'b1, lccp_pkg::ST_BADPTR);
        end else begin
          n = 0;
          while (!stop) begin
            if (cell_text[cur] == 8'h00) begin
              add_result(cur, 8'h00, 1'b1, lccp_pkg::ST_OK);
              stop = 1'b1;
            end else if (n + 1 >= MAX_READ) begin
              add_result(cur, cell_text[cur], 1'b1, lccp_pkg::ST_TRUNC);
              stop = 1'b1;
            end else if (cell_next[cur] >= POOL_CELLS) begin
              add_result(cur, cell_text[cur], 1'b1, lccp_pkg::ST_BADPTR);
              stop = 1'b1;
            end else begin
              add_result(cur, cell_text[cur], 1'b0, lccp_pkg::ST_OK);
              n++;
              cur = int'(cell_next[cur]);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] random_cell();
    return IDX_W'($urandom_range(0, POOL_CELLS - 1));
  endfunction

  // Offers one request, with random idle cycles ahead of it, and updates the
  // shadow pool on the edge where the pool takes it. Valid is left high so
  // that back-to-back requests need no second assignment in one time step.
  task automatic drive_request(input logic [1:0] mode, input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0] ptr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.char_value <= ch;
    req_if.pointer    <= ptr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_request(mode, ch, ptr);
    if (mode != MODE_UNUSED) requests_sent++;
  endtask

  task automatic issue_request(input logic [1:0] mode, input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0] ptr);
    drive_request(mode, ch, ptr);
    foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
  endtask

  // A well-formed string: consecutive allocs from the free head, so the
  // cells end up chained in order, closed by a zero byte.
  task automatic alloc_string(input int len);
    if (next_free < POOL_CELLS) live_strings.push_back(int'(next_free));
    for (int i = 0; i < len; i++)
      issue_request(lccp_pkg::MODE_ALLOC, CHAR_W'($urandom_range(1, 255)), random_cell());
    issue_request(lccp_pkg::MODE_ALLOC, 8'h00, random_cell());
  endtask

  task automatic free_live_string(input int k);
    issue_request(lccp_pkg::MODE_FREE, CHAR_W'($urandom), IDX_W'(live_strings[k]));
    live_strings.delete(k);
  endtask

  // One string longer than a read may return: the read of it stops on the
  // last cell it is allowed to emit, and the free walks all of it.
  task automatic long_string();
    alloc_string(MAX_READ + 7);
    issue_request(lccp_pkg::MODE_READ, 8'h00,
                  IDX_W'(live_strings[live_strings.size() - 1]));
    free_live_string(live_strings.size() - 1);
  endtask

  // Mostly whole strings that are later read and freed, with some noise:
  // reads and frees at random cells, lone allocs and the unused mode.
  task automatic run_random(input int items);
    int done_items;
    int pick;
    int len;
    done_items = 0;
    while (done_items < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(1, 8);
        alloc_string(len);
        done_items += len + 1;
      end else if (pick < 58 && live_strings.size() != 0) begin
        issue_request(lccp_pkg::MODE_READ, CHAR_W'($urandom),
                      IDX_W'(live_strings[$urandom_range(0, live_strings.size() - 1)]));
        done_items++;
      end else if (pick < 72 && live_strings.size() != 0) begin
        free_live_string($urandom_range(0, live_strings.size() - 1));
        done_items++;
      end else if (pick < 80) begin
        issue_request(lccp_pkg::MODE_READ, CHAR_W'($urandom), random_cell());
        done_items++;
      end else if (pick < 86) begin
        issue_request(lccp_pkg::MODE_FREE, CHAR_W'($urandom), random_cell());
        done_items++;
      end else if (pick < 94) begin
        issue_request(lccp_pkg::MODE_ALLOC, CHAR_W'($urandom), random_cell());
        done_items++;
      end else begin
        issue_request(MODE_UNUSED, CHAR_W'($urandom), random_cell());
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Compares one taken result with the oldest one owed, field by field.
  task automatic check_result();
    pool_result_t got;
    pool_result_t want;
    got = '{res_if.cell_index, res_if.char_out, res_if.last, res_if.status};
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed: cell %0d char %02h last %0b st %0d",
                                got.cell_index, got.char_out, got.last, got.status));
    end else begin
      want = awaited_results.pop_front();
      results_checked++;
      if (want.status == lccp_pkg::ST_FULL) full_seen++;
      if (want.status == lccp_pkg::ST_TRUNC) truncated_seen++;
      if (want.status == lccp_pkg::ST_BADPTR) broken_seen++;
      if (got.cell_index != want.cell_index)
        report_mismatch($sformatf("cell_index %0d, expected %0d",
                                  got.cell_index, want.cell_index));
      if (got.char_out != want.char_out)
        report_mismatch($sformatf("char_out %02h, expected %02h at cell %0d",
                                  got.char_out, want.char_out, want.cell_index));
      if (got.last != want.last)
        report_mismatch($sformatf("last %0b, expected %0b at cell %0d",
                                  got.last, want.last, want.cell_index));
      if (got.status != want.status)
        report_mismatch($sformatf("status %0d, expected %0d at cell %0d",
                                  got.status, want.status, want.cell_index));
    end
  endtask

  // Result side: checks on the edge where a result is taken, then picks the
  // ready level for the next cycle. The watchdog runs here as well and
  // counts edges on which neither channel moved anything.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) check_result();
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no request or result moved for %0d cycles, %0d results owed",
                   WATCHDOG_LIMIT, awaited_results.size());
          $display("tb_linked_char_cell_pool: done, errors");
          $finish;
        end
      end
    end
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.mode       <= lccp_pkg::MODE_ALLOC;
    req_if.char_value <= '0;
    req_if.pointer    <= '0;

    // The shadow pool starts as the pool does after its clearing sweep.
    for (int i = 0; i < POOL_CELLS; i++) begin
      cell_text[i] = '0;
      cell_next[i] = LINK_W'(i + 1);
    end
    next_free = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Slow sender, slower receiver: results pile up in the output register.
    send_idle_pct = 27;
    recv_idle_pct = 79;
    for (int i = 0; i < N_ROWS; i++) begin
      drive_request(directed_rows[i].mode, directed_rows[i].char_value,
                    directed_rows[i].pointer);
      if (directed_rows[i].typed) awaited_results.push_back(directed_rows[i].want);
      else foreach (fresh_results[j]) awaited_results.push_back(fresh_results[j]);
    end
    long_string();
    run_random(40);

    // Sparse requests against an eager receiver.
    send_idle_pct = 79;
    recv_idle_pct = 27;
    run_random(40);

    // Both sides flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(30);

    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d mismatches", requests_sent,
             results_checked, mismatches);
    $display("pool full %0d times, %0d truncated reads, %0d reads off a broken chain",
             full_seen, truncated_seen, broken_seen);
    if (mismatches == 0) begin
      $display("tb_linked_char_cell_pool: done, clean");
    end else begin
      $display("tb_linked_char_cell_pool: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
